/* rtl/core/bounded_lifo_stack_with_dump_core_assert.svh */
// ----------------------------------------------------------------------------
// bounded lifo stack assertion macros
// clocked assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIFO_STACK_WITH_DUMP_CORE_ASSERT_SVH
`define BOUNDED_LIFO_STACK_WITH_DUMP_CORE_ASSERT_SVH

// assertion that is switched off while reset is low
`define BLD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is also checked during reset
`define BLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bld_pkg.sv */
// ----------------------------------------------------------------------------
// bld_pkg
// shared types and codes of the bounded lifo stack
// ----------------------------------------------------------------------------
`default_nettype none

package bld_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 6;

  // request codes
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_DUMP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [CNT_W-1:0]         CAP_RESET   = 6'd32;
  localparam logic signed [WORD_W-1:0] EMPTY_VALUE = -32'sd1;
  localparam logic signed [WORD_W-1:0] ZERO_VALUE  = 32'sd0;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_OVERFLOW = 3'd1,
    OP_POP      = 3'd2,
    OP_EMPTY    = 3'd3,
    OP_DUMP     = 3'd4
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [CNT_W-1:0]        addr;   // entry to write or first entry to read
    logic [CNT_W-1:0]        depth;  // depth after the request
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bld_queue.sv */
// ----------------------------------------------------------------------------
// bld_queue
// two-entry command queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module bld_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bld_pkg::cmd_t  cmd_i,
  input  wire logic           pop_i,
  output bld_pkg::cmd_t       cmd_o,
  output bld_pkg::q_stat_t    stat_o
);

  bld_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = entry_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

`default_nettype wire

/* rtl/core/bld_front.sv */
// ----------------------------------------------------------------------------
// bld_front
// accepts requests, tracks the fill count and classifies each request
// ----------------------------------------------------------------------------
`default_nettype none

module bld_front #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic signed [bld_pkg::WORD_W-1:0] push_value_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [bld_pkg::CNT_W-1:0]      cfg_data_i,
  output logic                                enq_o,
  output bld_pkg::cmd_t                       cmd_o
);

  localparam logic [bld_pkg::CNT_W:0] DEPTH_X = (bld_pkg::CNT_W+1)'(DEPTH);

  logic [bld_pkg::CNT_W-1:0] cap_q;
  logic [bld_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [bld_pkg::CNT_W-1:0] limit;

  // capacity clipped to the physical store
  assign limit = ({1'b0, cap_q} < DEPTH_X) ? cap_q : bld_pkg::CNT_W'(DEPTH);

  always_comb begin
    fill_d      = fill_q;
    enq_o       = 1'b0;
    cmd_o.op    = bld_pkg::OP_EMPTY;
    cmd_o.addr  = fill_q;
    cmd_o.depth = fill_q;
    cmd_o.value = push_value_i;
    if (accept_i) begin
      unique case (req_type_i)
        bld_pkg::REQ_PUSH: begin
          enq_o = 1'b1;
          if (fill_q < limit) begin
            cmd_o.op    = bld_pkg::OP_PUSH;
            cmd_o.depth = fill_q + 1'b1;
            fill_d      = fill_q + 1'b1;
          end else begin
            cmd_o.op = bld_pkg::OP_OVERFLOW;
          end
        end
        bld_pkg::REQ_POP: begin
          enq_o = 1'b1;
          if (fill_q != '0) begin
            cmd_o.op    = bld_pkg::OP_POP;
            cmd_o.addr  = fill_q - 1'b1;
            cmd_o.depth = fill_q - 1'b1;
            fill_d      = fill_q - 1'b1;
          end else begin
            cmd_o.op    = bld_pkg::OP_EMPTY;
            cmd_o.depth = '0;
          end
        end
        bld_pkg::REQ_DUMP: begin
          enq_o = 1'b1;
          if (fill_q != '0) begin
            cmd_o.op   = bld_pkg::OP_DUMP;
            cmd_o.addr = fill_q - 1'b1;
          end else begin
            cmd_o.op    = bld_pkg::OP_EMPTY;
            cmd_o.depth = '0;
          end
        end
        default: begin
          enq_o = 1'b0;  // unused code, dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= bld_pkg::CAP_RESET;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bld_back.sv */
// ----------------------------------------------------------------------------
// bld_back
// word store, pop and push access, dump walk and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module bld_back #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bld_pkg::cmd_t                     cmd_i,
  input  wire bld_pkg::q_stat_t                  q_stat_i,
  output logic                                   pop_o,
  output logic                                   res_strobe_o,
  output logic [1:0]                             status_o,
  output logic signed [bld_pkg::WORD_W-1:0]      value_o,
  output logic [bld_pkg::CNT_W-1:0]              depth_after_o,
  output logic                                   is_last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic signed [bld_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [bld_pkg::WORD_W-1:0] rd_q;
  logic [AW-1:0]                     rd_addr;
  logic [AW-1:0]                     cmd_addr;
  logic                              mem_we;

  logic [AW-1:0]              walk_addr_q, walk_addr_d;
  logic [bld_pkg::CNT_W-1:0]  walk_depth_q, walk_depth_d;

  logic                              valid_q, valid_d;
  logic [1:0]                        status_q, status_d;
  logic [bld_pkg::CNT_W-1:0]         depth_q, depth_d;
  logic                              last_q, last_d;
  logic                              from_mem_q, from_mem_d;
  logic signed [bld_pkg::WORD_W-1:0] const_q, const_d;

  assign cmd_addr = cmd_i.addr[AW-1:0];
  assign pop_o    = q_stat_i.valid && (state_q == S_RUN);
  assign rd_addr  = (state_q == S_WALK) ? walk_addr_q : cmd_addr;

  always_comb begin
    state_d      = state_q;
    walk_addr_d  = walk_addr_q;
    walk_depth_d = walk_depth_q;
    mem_we       = 1'b0;
    valid_d      = 1'b0;
    status_d     = bld_pkg::ST_OK;
    depth_d      = cmd_i.depth;
    last_d       = 1'b1;
    from_mem_d   = 1'b0;
    const_d      = bld_pkg::ZERO_VALUE;
    unique case (state_q)
      S_WALK: begin
        valid_d    = 1'b1;
        depth_d    = walk_depth_q;
        from_mem_d = 1'b1;
        last_d     = (walk_addr_q == '0);
        if (walk_addr_q == '0) begin
          state_d = S_RUN;
        end else begin
          walk_addr_d = walk_addr_q - 1'b1;
        end
      end
      S_RUN: begin
        if (pop_o) begin
          valid_d = 1'b1;
          unique case (cmd_i.op)
            bld_pkg::OP_PUSH: begin
              mem_we = 1'b1;
            end
            bld_pkg::OP_OVERFLOW: begin
              status_d = bld_pkg::ST_OVERFLOW;
            end
            bld_pkg::OP_POP: begin
              from_mem_d = 1'b1;
            end
            bld_pkg::OP_EMPTY: begin
              status_d = bld_pkg::ST_EMPTY;
              const_d  = bld_pkg::EMPTY_VALUE;
            end
            bld_pkg::OP_DUMP: begin
              from_mem_d = 1'b1;
              last_d     = (cmd_addr == '0);
              if (cmd_addr != '0) begin
                state_d      = S_WALK;
                walk_addr_d  = cmd_addr - 1'b1;
                walk_depth_d = cmd_i.depth;
              end
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_addr] <= cmd_i.value;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_addr_q  <= walk_addr_d;
    walk_depth_q <= walk_depth_d;
    status_q     <= status_d;
    depth_q      <= depth_d;
    last_q       <= last_d;
    from_mem_q   <= from_mem_d;
    const_q      <= const_d;
  end

  assign res_strobe_o  = valid_q;
  assign status_o      = status_q;
  assign value_o       = from_mem_q ? rd_q : const_q;
  assign depth_after_o = depth_q;
  assign is_last_o     = last_q;

endmodule

`default_nettype wire

/* rtl/core/bounded_lifo_stack_with_dump_core.sv */
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_dump_core
// bounded lifo stack of signed words with push, pop and dump requests
// ----------------------------------------------------------------------------
// a request is taken when start_i is high and busy_o is low. every result
// word is shown for exactly one cycle with res_strobe_o high and must be
// taken then: there is no way to hold results off. a push or pop gives one
// word via the command queue and result registers; a dump of n held words
// gives n words back to back, top to bottom, is_last_o high on the bottom
// one. a dump of an empty stack gives one word with status empty. push and
// pop run at one request per cycle while no dump walk holds the back end on
// its store read port; once the two-entry command queue is full busy_o
// stays high until the walk frees it. request code 3 is taken and dropped.
// the capacity register is written over the cfg channel, which is always
// ready, and must only be written while no result is pending. no clearing
// pass after reset: the fill count keeps every read inside written entries.
`default_nettype none

module bounded_lifo_stack_with_dump_core #(
  parameter int unsigned DEPTH = 32  // words in the store, 1 to 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic signed [bld_pkg::WORD_W-1:0] push_value_i,
  // capacity write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bld_pkg::CNT_W-1:0]         cfg_data_i,
  // result channel
  output logic                                   res_strobe_o,
  output logic [1:0]                             status_o,
  output logic signed [bld_pkg::WORD_W-1:0]      value_o,
  output logic [bld_pkg::CNT_W-1:0]              depth_after_o,
  output logic                                   is_last_o
);

  logic             accept;
  logic             enq;
  logic             deq;
  bld_pkg::cmd_t    front_cmd;
  bld_pkg::cmd_t    queue_cmd;
  bld_pkg::q_stat_t q_stat;

  // front stalls only on a full queue
  assign busy_o      = q_stat.full;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // front: capacity register, fill count, request classification
  bld_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .enq_o        (enq),
    .cmd_o        (front_cmd)
  );

  // decouples the front from the dump walk
  bld_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (enq),
    .cmd_i  (front_cmd),
    .pop_i  (deq),
    .cmd_o  (queue_cmd),
    .stat_o (q_stat)
  );

  // back: word store access and result words
  bld_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (queue_cmd),
    .q_stat_i      (q_stat),
    .pop_o         (deq),
    .res_strobe_o  (res_strobe_o),
    .status_o      (status_o),
    .value_o       (value_o),
    .depth_after_o (depth_after_o),
    .is_last_o     (is_last_o)
  );

endmodule

`default_nettype wire

/* rtl/core/bld_checker.sv */
// ----------------------------------------------------------------------------
// bld_checker
// port level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_lifo_stack_with_dump_core_assert.svh"

module bld_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              res_strobe_o,
  input wire logic [1:0]                        status_o,
  input wire logic signed [bld_pkg::WORD_W-1:0] value_o,
  input wire logic [bld_pkg::CNT_W-1:0]         depth_after_o,
  input wire logic                              is_last_o
);

  // no result word while in reset
  `BLD_ASSERT_ALWAYS(a_no_res_in_reset, clk_i, !rst_ni |-> !res_strobe_o, "result during reset")

  // a dump walk runs without gaps at a constant depth
  `BLD_ASSERT(a_dump_walk, clk_i, rst_ni, res_strobe_o && !is_last_o |=> res_strobe_o && status_o == bld_pkg::ST_OK && $stable(depth_after_o), "dump walk broken")

  // empty results carry all ones, depth zero and the last mark
  `BLD_ASSERT(a_empty_res, clk_i, rst_ni, res_strobe_o && status_o == bld_pkg::ST_EMPTY |-> value_o == bld_pkg::EMPTY_VALUE && depth_after_o == '0 && is_last_o, "bad empty result")

  // overflow results carry a zero word and the last mark
  `BLD_ASSERT(a_ovf_res, clk_i, rst_ni, res_strobe_o && status_o == bld_pkg::ST_OVERFLOW |-> value_o == bld_pkg::ZERO_VALUE && is_last_o, "bad overflow result")

endmodule

bind bounded_lifo_stack_with_dump_core bld_checker u_bld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_strobe_o  (res_strobe_o),
  .status_o      (status_o),
  .value_o       (value_o),
  .depth_after_o (depth_after_o),
  .is_last_o     (is_last_o)
);

`default_nettype wire

/* tb/sv/bounded_lifo_stack_with_dump_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded lifo stack testbench
// drives push, pop and dump requests in random bursts, mirrors the stack in
// a local model and checks every result word as it appears
// ----------------------------------------------------------------------------

module bounded_lifo_stack_with_dump_core_tb;

  localparam int unsigned STACK_DEPTH = 32;
  // request code that the block takes and drops
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // one request waiting to go out
  typedef struct {
    logic [1:0]                        kind;
    logic signed [bld_pkg::WORD_W-1:0] word;
  } stack_req_t;

  // one result word the stack owes us
  typedef struct {
    logic [1:0]                        status;
    logic signed [bld_pkg::WORD_W-1:0] value;
    logic [bld_pkg::CNT_W-1:0]         depth;
    logic                              last;
  } stack_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start_i = 1'b0;
  logic [1:0]                        req_type_i = bld_pkg::REQ_PUSH;
  logic signed [bld_pkg::WORD_W-1:0] push_value_i = '0;
  logic                              cfg_valid_i = 1'b0;
  logic [bld_pkg::CNT_W-1:0]         cfg_data_i = bld_pkg::CAP_RESET;
  logic                              busy_o;
  logic                              cfg_ready_o;
  logic                              res_strobe_o;
  logic [1:0]                        status_o;
  logic signed [bld_pkg::WORD_W-1:0] value_o;
  logic [bld_pkg::CNT_W-1:0]         depth_after_o;
  logic                              is_last_o;

  bounded_lifo_stack_with_dump_core #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .status_o     (status_o),
    .value_o      (value_o),
    .depth_after_o(depth_after_o),
    .is_last_o    (is_last_o)
  );

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #500us;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // local copy of the stack: held words, fill and capacity register
  // --------------------------------------------------------------------------
  logic signed [bld_pkg::WORD_W-1:0] held_words [STACK_DEPTH];
  int unsigned                       held_count = 0;
  logic [bld_pkg::CNT_W-1:0]         cap_reg = bld_pkg::CAP_RESET;

  stack_req_t    req_backlog [$];   // requests not yet offered
  stack_result_t owed_results [$];  // result words still to come, oldest first

  // run statistics
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned peak_fill = 0;
  int unsigned n_overflow = 0;
  int unsigned n_empty = 0;
  int unsigned kind_count [4] = '{0, 0, 0, 0};

  function automatic void owe(input logic [1:0] status,
                              input logic signed [bld_pkg::WORD_W-1:0] value,
                              input int unsigned depth, input logic last);
    stack_result_t r;
    r.status = status;
    r.value  = value;
    r.depth  = depth[bld_pkg::CNT_W-1:0];
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // apply one accepted request to the local stack and queue its result words
  function automatic void apply_request(input logic [1:0] kind,
                                        input logic signed [bld_pkg::WORD_W-1:0] word);
    int unsigned lim;
    int          i;
    // capacity above the store size still tops out at the store size
    lim = (cap_reg < STACK_DEPTH) ? cap_reg : STACK_DEPTH;
    kind_count[kind]++;
    case (kind)
      bld_pkg::REQ_PUSH: begin
        // full, zero capacity, or capacity lowered below the fill: word dropped
        if (held_count < lim) begin
          held_words[held_count] = word;
          held_count++;
          if (held_count > peak_fill) peak_fill = held_count;
          owe(bld_pkg::ST_OK, bld_pkg::ZERO_VALUE, held_count, 1'b1);
        end else begin
          n_overflow++;
          owe(bld_pkg::ST_OVERFLOW, bld_pkg::ZERO_VALUE, held_count, 1'b1);
        end
      end
      bld_pkg::REQ_POP: begin
        if (held_count > 0) begin
          held_count--;
          owe(bld_pkg::ST_OK, held_words[held_count], held_count, 1'b1);
        end else begin
          n_empty++;
          owe(bld_pkg::ST_EMPTY, bld_pkg::EMPTY_VALUE, 0, 1'b1);
        end
      end
      bld_pkg::REQ_DUMP: begin
        if (held_count == 0) begin
          n_empty++;
          owe(bld_pkg::ST_EMPTY, bld_pkg::EMPTY_VALUE, 0, 1'b1);
        end else begin
          // top to bottom, nothing removed, last flag on the bottom word
          for (i = held_count - 1; i >= 0; i--)
            owe(bld_pkg::ST_OK, held_words[i], held_count, i == 0);
        end
      end
      default: begin
        // unused code: no result, no state change
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers backlog words in bursts with random gaps
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  stack_req_t  next_req;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      // word taken at this edge
      if (start_i && !busy_o) apply_request(req_type_i, push_value_i);

      if (start_i && busy_o) begin
        // block is busy, keep the word on the port
      end else if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        next_req = req_backlog.pop_front();
        start_i      <= 1'b1;
        req_type_i   <= next_req.kind;
        push_value_i <= next_req.word;
        if (burst_left <= 1) begin
          // new burst; a quarter of them follow back to back with no gap
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every strobed word is checked against the oldest owed result
  // --------------------------------------------------------------------------
  stack_result_t seen_due;

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual status %0d value %0d",
                 $time, status_o, value_o);
        $display("%0t:   depth %0d last %0b", $time, depth_after_o, is_last_o);
      end else begin
        seen_due = owed_results.pop_front();
        words_checked++;
        check_field("status", {62'd0, seen_due.status}, {62'd0, status_o});
        check_field("value", seen_due.value, value_o);
        check_field("depth_after", {58'd0, seen_due.depth}, {58'd0, depth_after_o});
        check_field("is_last", {63'd0, seen_due.last}, {63'd0, is_last_o});
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] kind,
                            input logic signed [bld_pkg::WORD_W-1:0] word);
    stack_req_t r;
    r.kind = kind;
    r.word = word;
    req_backlog.push_back(r);
  endtask

  // wait until every request went out and every owed word came back,
  // then a few more cycles since an unused code leaves no result to wait for
  task automatic settle;
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || start_i || owed_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [bld_pkg::CNT_W-1:0] cap);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cap_reg = cap;
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // extremes often, random words otherwise
  function automatic logic signed [bld_pkg::WORD_W-1:0] pick_word;
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return bld_pkg::EMPTY_VALUE;
      3:       return bld_pkg::ZERO_VALUE;
      default: return $urandom;
    endcase
  endfunction

  // push share in percent; the rest is mostly pops, some dumps, a few unused codes
  function automatic logic [1:0] pick_kind(input int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < push_pct) return bld_pkg::REQ_PUSH;
    r = $urandom_range(0, 99);
    if (r < 68) return bld_pkg::REQ_POP;
    if (r < 93) return bld_pkg::REQ_DUMP;
    return REQ_UNUSED;
  endfunction

  // random phases: capacity, number of requests, push share
  // first phase fills the store; the next one lowers the capacity under the fill
  int unsigned phase_cap  [6] = '{63, 5, 1, 0, 32, 17};
  int unsigned phase_len  [6] = '{45, 25, 20, 15, 45, 30};
  int unsigned phase_push [6] = '{80, 50, 50, 40, 70, 45};

  initial begin : stimulus
    int unsigned p;
    int unsigned n;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset capacity: empty pop and dump, extreme words, unused code
    queue_item(bld_pkg::REQ_POP, bld_pkg::ZERO_VALUE);
    queue_item(bld_pkg::REQ_DUMP, bld_pkg::ZERO_VALUE);
    queue_item(bld_pkg::REQ_PUSH, 32'sh7fff_ffff);
    queue_item(bld_pkg::REQ_PUSH, 32'sh8000_0000);
    queue_item(bld_pkg::REQ_PUSH, bld_pkg::EMPTY_VALUE);
    queue_item(bld_pkg::REQ_PUSH, bld_pkg::ZERO_VALUE);
    queue_item(bld_pkg::REQ_DUMP, bld_pkg::ZERO_VALUE);
    queue_item(REQ_UNUSED, 32'sh1234_5678);
    repeat (5) queue_item(bld_pkg::REQ_POP, bld_pkg::ZERO_VALUE);
    settle();

    // small capacity: push into a full stack
    set_capacity(6'd2);
    queue_item(bld_pkg::REQ_PUSH, 32'sh5a5a_5a5a);
    queue_item(bld_pkg::REQ_PUSH, 32'sha5a5_a5a5);
    queue_item(bld_pkg::REQ_PUSH, 32'sh0000_0001);
    queue_item(bld_pkg::REQ_DUMP, bld_pkg::ZERO_VALUE);
    settle();

    // zero capacity with words still held
    set_capacity(6'd0);
    queue_item(bld_pkg::REQ_PUSH, 32'sh0bad_cafe);
    queue_item(bld_pkg::REQ_DUMP, bld_pkg::ZERO_VALUE);
    queue_item(bld_pkg::REQ_POP, bld_pkg::ZERO_VALUE);
    settle();

    // capacity above the store size
    set_capacity(6'd63);
    queue_item(bld_pkg::REQ_PUSH, 32'sh7654_3210);
    queue_item(bld_pkg::REQ_DUMP, bld_pkg::ZERO_VALUE);
    settle();

    // random phases, each under its own capacity
    for (p = 0; p < 6; p++) begin
      set_capacity(phase_cap[p][bld_pkg::CNT_W-1:0]);
      for (n = 0; n < phase_len[p]; n++) queue_item(pick_kind(phase_push[p]), pick_word());
      settle();
    end

    repeat (10) @(posedge clk_i);
    $display("requests: %0d push, %0d pop, %0d dump, %0d unused; %0d result words checked",
             kind_count[bld_pkg::REQ_PUSH], kind_count[bld_pkg::REQ_POP],
             kind_count[bld_pkg::REQ_DUMP], kind_count[REQ_UNUSED], words_checked);
    $display("capacity writes %0d, overflows %0d, empty results %0d, deepest fill %0d",
             cfg_writes, n_overflow, n_empty, peak_fill);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bld_pkg.sv
rtl/core/bld_queue.sv
rtl/core/bld_front.sv
rtl/core/bld_back.sv
rtl/core/bounded_lifo_stack_with_dump_core.sv
rtl/core/bld_checker.sv
tb/sv/bounded_lifo_stack_with_dump_core_tb.sv
